@@ hw/rtl/wmp_pkg.sv @@
`timescale 1ns / 1ps

package wmp_pkg;

    localparam int IDX_W  = 6;   // enough for up to 64 table entries
    localparam int AREA_W = 30;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PLACE = 1'b1;

    localparam logic [1:0] OUT_FULL    = 2'd0;
    localparam logic [1:0] OUT_OUTSIDE = 2'd1;
    localparam logic [1:0] OUT_CLAMP   = 2'd2;
    localparam logic [1:0] OUT_LOAD    = 2'd3;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } rect_t;

    // Window plus running search result, handed from cell to cell
    typedef struct packed {
        logic               vld;
        rect_t              win;
        logic [AREA_W-1:0]  carea;
        logic               full;
        logic [IDX_W-1:0]   best_idx;
        logic [AREA_W-1:0]  best_area;
        logic signed [15:0] best_x;
        logic signed [15:0] best_y;
        logic [14:0]        best_w;
        logic [14:0]        best_h;
        logic               found;
        logic [AREA_W-1:0]  t_area;
        rect_t              t_mon;
    } tok_t;

endpackage

@@ hw/rtl/wmp_cell.sv @@
`timescale 1ns / 1ps

module wmp_cell #(
    parameter int IDX = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  wmp_pkg::rect_t wr_mon,
    input  logic           active,
    input  wmp_pkg::tok_t  tok_i,
    output wmp_pkg::tok_t  tok_o
);

    wmp_pkg::rect_t mon_reg;
    wmp_pkg::tok_t  tok_reg;
    wmp_pkg::tok_t  tok_next;

    logic signed [16:0] wx1, wx2, mx1, mx2, wy1, wy2, my1, my2;
    logic signed [16:0] lox, hix, loy, hiy, dx, dy;
    logic [14:0] ox, oy;
    logic [wmp_pkg::AREA_W-1:0] area;
    logic take_best, take_tgt;

    always_comb
    begin
        wx1 = 17'(tok_i.win.x);
        wx2 = wx1 + $signed({2'b00, tok_i.win.w});
        mx1 = 17'(mon_reg.x);
        mx2 = mx1 + $signed({2'b00, mon_reg.w});
        wy1 = 17'(tok_i.win.y);
        wy2 = wy1 + $signed({2'b00, tok_i.win.h});
        my1 = 17'(mon_reg.y);
        my2 = my1 + $signed({2'b00, mon_reg.h});
        lox = (wx1 > mx1) ? wx1 : mx1;
        hix = (wx2 < mx2) ? wx2 : mx2;
        loy = (wy1 > my1) ? wy1 : my1;
        hiy = (wy2 < my2) ? wy2 : my2;
        dx  = hix - lox;
        dy  = hiy - loy;
        ox  = (hix > lox) ? dx[14:0] : 15'd0;
        oy  = (hiy > loy) ? dy[14:0] : 15'd0;
        area = ox * oy;

        // cell 0 always seeds the best choice
        take_best = (IDX == 0) || (area > tok_i.best_area);
        take_tgt  = (area != '0) && (tok_i.win.w < mon_reg.w) &&
                    (tok_i.win.h < mon_reg.h) && (area > tok_i.t_area);

        tok_next = tok_i;
        if (active)
        begin
            if (area == tok_i.carea)
                tok_next.full = 1'b1;
            if (take_best)
            begin
                tok_next.best_idx  = wmp_pkg::IDX_W'(IDX);
                tok_next.best_area = area;
                tok_next.best_x    = mon_reg.x;
                tok_next.best_y    = mon_reg.y;
                tok_next.best_w    = mon_reg.w;
                tok_next.best_h    = mon_reg.h;
            end
            if (take_tgt)
            begin
                tok_next.found  = 1'b1;
                tok_next.t_area = area;
                tok_next.t_mon  = mon_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mon_reg <= '0;
            tok_reg <= '0;
        end
        else
        begin
            if (wr_en)
                mon_reg <= wr_mon;
            tok_reg <= tok_next;
        end
    end

    assign tok_o = tok_reg;

endmodule

@@ hw/rtl/wmp_chain.sv @@
`timescale 1ns / 1ps

module wmp_chain #(
    parameter int MAX_MONITORS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [wmp_pkg::IDX_W-1:0]   wr_idx,
    input  wmp_pkg::rect_t              wr_mon,
    input  logic [6:0]                  n_active,
    input  wmp_pkg::tok_t               tok_i,
    output wmp_pkg::tok_t               tok_o
);

    wmp_pkg::tok_t link [MAX_MONITORS+1];

    assign link[0] = tok_i;

    for (genvar i = 0; i < MAX_MONITORS; i++)
    begin : g_cell
        wmp_cell #(.IDX(i)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .wr_en  (wr_en && (wr_idx == wmp_pkg::IDX_W'(i))),
            .wr_mon (wr_mon),
            .active (n_active > 7'(i)),
            .tok_i  (link[i]),
            .tok_o  (link[i+1])
        );
    end

    assign tok_o = link[MAX_MONITORS];

endmodule

@@ hw/rtl/window_monitor_placement.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_ready  command, monitor_index, pos_x, pos_y, size_w, size_h
// out       output     out_valid/out_ready  new_x, new_y, outcome, best_monitor, mon_width,
//                                           mon_height
// cfg       input      cfg_we (no stall)    cfg_wdata = monitor_count
//
// Load: result registered at the transfer edge.
// Place: window and area product registered at the transfer edge, then passed through
//   the register of each table cell (MAX_MONITORS), then the result register.
// One item in flight; in_ready drops while a place runs or a result waits.
// Reset clears the table to zero and monitor_count to 1.

module window_monitor_placement #(
    parameter int MAX_MONITORS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic [2:0]         monitor_index,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic [14:0]        size_w,
    input  logic [14:0]        size_h,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] new_x,
    output logic signed [15:0] new_y,
    output logic [1:0]         outcome,
    output logic [2:0]         best_monitor,
    output logic [14:0]        mon_width,
    output logic [14:0]        mon_height
);

    logic [3:0] count_reg;
    logic       busy_reg;
    logic       out_valid_reg;
    logic signed [15:0] nx_reg, ny_reg;
    logic [1:0]  outcome_reg;
    logic [2:0]  best_reg;
    logic [14:0] mw_reg, mh_reg;

    wmp_pkg::tok_t  inj_reg, inj_next, tok_end;
    wmp_pkg::rect_t in_rect, tgt;
    logic [6:0] n_active;
    logic       in_xfer, load_xfer, place_xfer;

    logic signed [17:0] x1, x2, y1, y2, wx, wy, wx2, wy2, cx, cy;
    logic signed [15:0] nx_c, ny_c;
    logic [1:0]  outcome_c;

    assign in_ready   = !busy_reg && !out_valid_reg;
    assign in_xfer    = in_valid && in_ready;
    assign load_xfer  = in_xfer && (command == wmp_pkg::CMD_LOAD);
    assign place_xfer = in_xfer && (command == wmp_pkg::CMD_PLACE);

    assign in_rect = '{x: pos_x, y: pos_y, w: size_w, h: size_h};

    // zero acts as one, above the table size acts as the table size
    always_comb
    begin
        if (count_reg == 4'd0)
            n_active = 7'd1;
        else if ({3'b000, count_reg} > 7'(MAX_MONITORS))
            n_active = 7'(MAX_MONITORS);
        else
            n_active = {3'b000, count_reg};
    end

    always_comb
    begin
        inj_next       = '0;
        inj_next.vld   = place_xfer;
        inj_next.win   = in_rect;
        inj_next.carea = size_w * size_h;
    end

    wmp_chain #(.MAX_MONITORS(MAX_MONITORS)) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (load_xfer),
        .wr_idx   (wmp_pkg::IDX_W'(monitor_index)),
        .wr_mon   (in_rect),
        .n_active (n_active),
        .tok_i    (inj_reg),
        .tok_o    (tok_end)
    );

    // clamp into the target monitor: best fitting one, else best overlap
    always_comb
    begin
        if (tok_end.found)
            tgt = tok_end.t_mon;
        else
            tgt = '{x: tok_end.best_x, y: tok_end.best_y,
                    w: tok_end.best_w, h: tok_end.best_h};
        x1  = 18'(tgt.x);
        y1  = 18'(tgt.y);
        x2  = x1 + $signed({3'b000, tgt.w});
        y2  = y1 + $signed({3'b000, tgt.h});
        wx  = 18'(tok_end.win.x);
        wy  = 18'(tok_end.win.y);
        wx2 = wx + $signed({3'b000, tok_end.win.w});
        wy2 = wy + $signed({3'b000, tok_end.win.h});
        cx  = wx;
        cy  = wy;
        if (wx < x1)
            cx = x1;
        else if (wx2 > x2)
            cx = x2 - $signed({3'b000, tok_end.win.w});
        if (wy < y1)
            cy = y1;
        else if (wy2 > y2)
            cy = y2 - $signed({3'b000, tok_end.win.h});
        nx_c = (cx < -18'sd32768) ? -16'sd32768 : cx[15:0];
        ny_c = (cy < -18'sd32768) ? -16'sd32768 : cy[15:0];

        if (tok_end.full)
            outcome_c = wmp_pkg::OUT_FULL;
        else if (tok_end.best_area == '0)
            outcome_c = wmp_pkg::OUT_OUTSIDE;
        else
            outcome_c = wmp_pkg::OUT_CLAMP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 4'd1;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            inj_reg       <= '0;
            nx_reg        <= '0;
            ny_reg        <= '0;
            outcome_reg   <= '0;
            best_reg      <= '0;
            mw_reg        <= '0;
            mh_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
                count_reg <= cfg_wdata;
            inj_reg <= inj_next;
            if (place_xfer)
                busy_reg <= 1'b1;
            else if (tok_end.vld)
                busy_reg <= 1'b0;

            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (load_xfer)
            begin
                out_valid_reg <= 1'b1;
                nx_reg        <= pos_x;
                ny_reg        <= pos_y;
                outcome_reg   <= wmp_pkg::OUT_LOAD;
                best_reg      <= monitor_index;
                mw_reg        <= size_w;
                mh_reg        <= size_h;
            end
            else if (tok_end.vld)
            begin
                out_valid_reg <= 1'b1;
                outcome_reg   <= outcome_c;
                best_reg      <= tok_end.best_idx[2:0];
                mw_reg        <= tok_end.best_w;
                mh_reg        <= tok_end.best_h;
                if (outcome_c == wmp_pkg::OUT_CLAMP)
                begin
                    nx_reg <= nx_c;
                    ny_reg <= ny_c;
                end
                else
                begin
                    nx_reg <= tok_end.win.x;
                    ny_reg <= tok_end.win.y;
                end
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_x        = nx_reg;
    assign new_y        = ny_reg;
    assign outcome      = outcome_reg;
    assign best_monitor = best_reg;
    assign mon_width    = mw_reg;
    assign mon_height   = mh_reg;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int  NUM_MON     = 8;
    localparam int  ITEM_TARGET = 1150;
    localparam int  DRAIN_WAIT  = NUM_MON + 6;   // place latency plus margin
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  LONG_HOLD   = 500;

    // One input transfer
    typedef struct {
        logic               cmd;
        logic [2:0]         idx;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } item_t;

    // One result transfer
    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic [1:0]         oc;
        logic [2:0]         bm;
        logic [14:0]        mw;
        logic [14:0]        mh;
    } placement_t;

    // Directed row: cnt >= 0 rewrites monitor_count before the row
    typedef struct {
        int   cnt;
        logic cmd;
        int   idx, x, y, w, h;
        bit   typed;
        int   ex, ey, eo, eb, ew, eh;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [3:0]         cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               command = wmp_pkg::CMD_LOAD;
    logic [2:0]         monitor_index = '0;
    logic signed [15:0] pos_x = '0;
    logic signed [15:0] pos_y = '0;
    logic [14:0]        size_w = '0;
    logic [14:0]        size_h = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
    logic [1:0]         outcome;
    logic [2:0]         best_monitor;
    logic [14:0]        mon_width;
    logic [14:0]        mon_height;

    // Shadow of the monitor table and count register
    longint mon_x[NUM_MON];
    longint mon_y[NUM_MON];
    longint mon_w[NUM_MON];
    longint mon_h[NUM_MON];
    int unsigned mon_count = 1;

    placement_t pending_q[$];
    int errors  = 0;
    int n_sent  = 0;
    int cycles  = 0;
    int tx_max  = 12;
    int rx_max  = 12;
    bit long_hold_req = 1'b0;

    window_monitor_placement #(.MAX_MONITORS(NUM_MON)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .monitor_index (monitor_index),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .size_w        (size_w),
        .size_h        (size_h),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .new_x         (new_x),
        .new_y         (new_y),
        .outcome       (outcome),
        .best_monitor  (best_monitor),
        .mon_width     (mon_width),
        .mon_height    (mon_height)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_q.size());
            $display("** window_monitor_placement: FAILED **");
            $finish;
        end
    end

    function automatic longint span_isect(input longint a1, input longint a2,
                                          input longint b1, input longint b2);
        longint lo, hi;
        lo = (a1 > b1) ? a1 : b1;
        hi = (a2 < b2) ? a2 : b2;
        return (hi > lo) ? hi - lo : 0;
    endfunction

    // Works out the placement for one transfer and tracks table writes
    function automatic placement_t place_window(input item_t it);
        placement_t r;
        longint px, py, sw, sh, carea, nx, ny, tmax, x1, x2, y1, y2;
        longint isect[NUM_MON];
        int     n, best, tgt;
        bit     full, found;
        px = it.x;
        py = it.y;
        sw = it.w;
        sh = it.h;
        if (it.cmd == wmp_pkg::CMD_LOAD)
        begin
            mon_x[it.idx] = px;
            mon_y[it.idx] = py;
            mon_w[it.idx] = sw;
            mon_h[it.idx] = sh;
            r.nx = it.x;
            r.ny = it.y;
            r.oc = wmp_pkg::OUT_LOAD;
            r.bm = it.idx;
            r.mw = it.w;
            r.mh = it.h;
            return r;
        end
        // zero acts as one, anything past the table as the table size
        n = (mon_count < 1) ? 1 : ((mon_count > NUM_MON) ? NUM_MON : mon_count);
        carea = sw * sh;
        best = 0;
        full = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            isect[i] = span_isect(px, px + sw, mon_x[i], mon_x[i] + mon_w[i]) *
                       span_isect(py, py + sh, mon_y[i], mon_y[i] + mon_h[i]);
            if (isect[i] == carea)
                full = 1'b1;
            if (isect[i] > isect[best])
                best = i;
        end
        nx = px;
        ny = py;
        if (full)
            r.oc = wmp_pkg::OUT_FULL;
        else if (isect[best] == 0)
            r.oc = wmp_pkg::OUT_OUTSIDE;
        else
        begin
            r.oc = wmp_pkg::OUT_CLAMP;
            tgt = best;
            tmax = 0;
            found = 1'b0;
            // prefer the largest overlap that the window strictly fits into
            for (int i = 0; i < n; i++)
            begin
                if (isect[i] != 0 && sw < mon_w[i] && sh < mon_h[i] && isect[i] > tmax)
                begin
                    tmax = isect[i];
                    tgt = i;
                    found = 1'b1;
                end
            end
            if (!found)
                tgt = best;
            x1 = mon_x[tgt];
            x2 = x1 + mon_w[tgt];
            y1 = mon_y[tgt];
            y2 = y1 + mon_h[tgt];
            if (nx < x1)
                nx = x1;
            else if (nx + sw > x2)
                nx = x2 - sw;
            if (ny < y1)
                ny = y1;
            else if (ny + sh > y2)
                ny = y2 - sh;
            // saturate to the 16-bit coordinate range
            if (nx < -32768) nx = -32768;
            if (nx > 32767)  nx = 32767;
            if (ny < -32768) ny = -32768;
            if (ny > 32767)  ny = 32767;
        end
        r.nx = nx[15:0];
        r.ny = ny[15:0];
        r.bm = best[2:0];
        r.mw = mon_w[best][14:0];
        r.mh = mon_h[best][14:0];
        return r;
    endfunction

    // Offer one item after a random gap; record what it must produce
    task automatic send_item(input item_t it, input bit typed, input placement_t given);
        int         gap;
        placement_t p;
        gap = (tx_max == 0) ? 0 : int'($urandom_range(0, tx_max));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= it.cmd;
        monitor_index <= it.idx;
        pos_x         <= it.x;
        pos_y         <= it.y;
        size_w        <= it.w;
        size_h        <= it.h;
        do
            @(posedge clk);
        while (!in_ready);
        p = place_window(it);
        pending_q.push_back(typed ? given : p);
        n_sent++;
    endtask

    // Register writes only once the block has drained
    task automatic write_count(input int v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[3:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        mon_count = {28'd0, v[3:0]};
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int         hold;
        placement_t e, a;
        @(posedge rst_n);
        forever
        begin
            hold = (rx_max == 0) ? 0 : int'($urandom_range(0, rx_max));
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            a = '{new_x, new_y, outcome, best_monitor, mon_width, mon_height};
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result transfer, actual %h", $time, a);
                errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (a.nx !== e.nx)
                begin
                    $display("%0t: new_x expected %0d actual %0d", $time, e.nx, a.nx);
                    errors++;
                end
                if (a.ny !== e.ny)
                begin
                    $display("%0t: new_y expected %0d actual %0d", $time, e.ny, a.ny);
                    errors++;
                end
                if (a.oc !== e.oc)
                begin
                    $display("%0t: outcome expected %0d actual %0d", $time, e.oc, a.oc);
                    errors++;
                end
                if (a.bm !== e.bm)
                begin
                    $display("%0t: best_monitor expected %0d actual %0d",
                             $time, e.bm, a.bm);
                    errors++;
                end
                if (a.mw !== e.mw)
                begin
                    $display("%0t: mon_width expected %0d actual %0d", $time, e.mw, a.mw);
                    errors++;
                end
                if (a.mh !== e.mh)
                begin
                    $display("%0t: mon_height expected %0d actual %0d", $time, e.mh, a.mh);
                    errors++;
                end
            end
        end
    end

    // Directed rows: empty table, echo of loads, full / clamp / outside / tie,
    // saturation at the low edge, counts of zero and above the table size
    dir_row_t dir_tab[] = '{
        '{-1, wmp_pkg::CMD_PLACE, 0, 100, 200, 50, 40,
          1, 100, 200, wmp_pkg::OUT_OUTSIDE, 0, 0, 0},
        '{-1, wmp_pkg::CMD_PLACE, 0, -32768, 32767, 0, 0,
          1, -32768, 32767, wmp_pkg::OUT_FULL, 0, 0, 0},
        '{-1, wmp_pkg::CMD_PLACE, 7, 32767, -32768, 32767, 32767,
          1, 32767, -32768, wmp_pkg::OUT_OUTSIDE, 0, 0, 0},
        '{-1, wmp_pkg::CMD_LOAD, 0, 0, 0, 1920, 1080,
          1, 0, 0, wmp_pkg::OUT_LOAD, 0, 1920, 1080},
        '{-1, wmp_pkg::CMD_LOAD, 1, 1920, 0, 1280, 1024,
          1, 1920, 0, wmp_pkg::OUT_LOAD, 1, 1280, 1024},
        '{-1, wmp_pkg::CMD_PLACE, 0, 100, 100, 800, 600, 0, 0, 0, 0, 0, 0, 0},
        '{-1, wmp_pkg::CMD_PLACE, 0, 1800, 100, 400, 300, 0, 0, 0, 0, 0, 0, 0},
        '{ 2, wmp_pkg::CMD_PLACE, 0, 1800, 100, 400, 300, 0, 0, 0, 0, 0, 0, 0},
        '{-1, wmp_pkg::CMD_PLACE, 0, -500, -500, 3000, 2000, 0, 0, 0, 0, 0, 0, 0},
        '{-1, wmp_pkg::CMD_PLACE, 0, 5000, 5000, 10, 10,
          1, 5000, 5000, wmp_pkg::OUT_OUTSIDE, 0, 1920, 1080},
        '{-1, wmp_pkg::CMD_PLACE, 0, 1820, 0, 200, 100, 0, 0, 0, 0, 0, 0, 0},
        '{-1, wmp_pkg::CMD_LOAD, 7, -32768, 32767, 32767, 0,
          1, -32768, 32767, wmp_pkg::OUT_LOAD, 7, 32767, 0},
        '{-1, wmp_pkg::CMD_LOAD, 6, -32768, -32768, 10, 32767,
          1, -32768, -32768, wmp_pkg::OUT_LOAD, 6, 10, 32767},
        '{ 8, wmp_pkg::CMD_PLACE, 0, -32763, -100, 5000, 50, 0, 0, 0, 0, 0, 0, 0},
        '{ 0, wmp_pkg::CMD_PLACE, 0, 100, 100, 800, 600, 0, 0, 0, 0, 0, 0, 0},
        '{15, wmp_pkg::CMD_PLACE, 0, 1800, 100, 400, 300, 0, 0, 0, 0, 0, 0, 0},
        '{-1, wmp_pkg::CMD_LOAD, 5, 32767, 32767, 32767, 32767,
          1, 32767, 32767, wmp_pkg::OUT_LOAD, 5, 32767, 32767},
        '{-1, wmp_pkg::CMD_PLACE, 0, 32000, 32000, 500, 500, 0, 0, 0, 0, 0, 0, 0}
    };

    initial
    begin
        item_t      it;
        placement_t given;
        int         phase, n_act, j, span, per_phase;
        int         first_counts[4];
        first_counts = '{0, 15, 8, 1};
        for (int i = 0; i < NUM_MON; i++)
        begin
            mon_x[i] = 0;
            mon_y[i] = 0;
            mon_w[i] = 0;
            mon_h[i] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (dir_tab[k])
        begin
            if (dir_tab[k].cnt >= 0)
                write_count(dir_tab[k].cnt);
            it.cmd = dir_tab[k].cmd;
            it.idx = 3'(dir_tab[k].idx);
            it.x   = 16'(dir_tab[k].x);
            it.y   = 16'(dir_tab[k].y);
            it.w   = 15'(dir_tab[k].w);
            it.h   = 15'(dir_tab[k].h);
            given  = '{16'(dir_tab[k].ex), 16'(dir_tab[k].ey), 2'(dir_tab[k].eo),
                       3'(dir_tab[k].eb), 15'(dir_tab[k].ew), 15'(dir_tab[k].eh)};
            send_item(it, dir_tab[k].typed, given);
        end

        // random part: each phase sets a count, lays out monitors, then
        // places windows around them with some noise and stray loads
        phase = 0;
        while (n_sent < ITEM_TARGET)
        begin
            write_count((phase < 4) ? first_counts[phase] : int'($urandom_range(0, 15)));
            tx_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            rx_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            if (phase == 2)
                long_hold_req = 1'b1;   // receiver stalls, sender keeps offering
            for (int i = 0; i < NUM_MON; i++)
            begin
                if ($urandom_range(0, 2) == 0 && phase > 0)
                    continue;           // keep the old entry now and then
                it.cmd = wmp_pkg::CMD_LOAD;
                it.idx = 3'(i);
                if ($urandom_range(0, 7) == 0)
                begin
                    it.x = 16'($urandom);
                    it.y = 16'($urandom);
                    it.w = 15'($urandom);
                    it.h = 15'($urandom);
                end
                else
                begin
                    it.x = 16'(int'($urandom_range(0, 6000)) - 3000);
                    it.y = 16'(int'($urandom_range(0, 6000)) - 3000);
                    it.w = 15'($urandom_range(1, 3000));
                    it.h = 15'($urandom_range(1, 3000));
                end
                send_item(it, 1'b0, given);
            end
            n_act = (mon_count < 1) ? 1 : ((mon_count > NUM_MON) ? NUM_MON : mon_count);
            per_phase = int'($urandom_range(20, 60));
            for (int k = 0; k < per_phase; k++)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        it.cmd = 1'($urandom);
                        it.idx = 3'($urandom);
                        it.x   = 16'($urandom);
                        it.y   = 16'($urandom);
                        it.w   = 15'($urandom);
                        it.h   = 15'($urandom);
                    end
                    1:
                    begin
                        it.cmd = wmp_pkg::CMD_LOAD;
                        it.idx = 3'($urandom);
                        it.x   = 16'(int'($urandom_range(0, 6000)) - 3000);
                        it.y   = 16'(int'($urandom_range(0, 6000)) - 3000);
                        it.w   = 15'($urandom_range(0, 3000));
                        it.h   = 15'($urandom_range(0, 3000));
                    end
                    default:
                    begin
                        j = int'($urandom_range(0, n_act - 1));
                        it.cmd = wmp_pkg::CMD_PLACE;
                        it.idx = 3'($urandom);
                        if ($urandom_range(0, 9) == 0)
                        begin
                            it.w = 15'($urandom);
                            it.h = 15'($urandom);
                        end
                        else
                        begin
                            it.w = 15'($urandom_range(0, 2500));
                            it.h = 15'($urandom_range(0, 2500));
                        end
                        // anywhere from just left of the monitor to past its edge
                        span = int'(mon_w[j]) + int'(it.w);
                        it.x = 16'(int'(mon_x[j]) - int'(it.w) +
                                   int'($urandom_range(0, span)));
                        span = int'(mon_h[j]) + int'(it.h);
                        it.y = 16'(int'(mon_y[j]) - int'(it.h) +
                                   int'($urandom_range(0, span)));
                    end
                endcase
                send_item(it, 1'b0, given);
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("** window_monitor_placement: PASSED **");
        else
            $display("** window_monitor_placement: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/wmp_pkg.sv
hw/rtl/wmp_cell.sv
hw/rtl/wmp_chain.sv
hw/rtl/window_monitor_placement.sv
sim/tb.sv
